// ===== rtl/lru_key_value_cache_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define LKVC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lru cache check failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define LKVC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lru cache check failed");

`endif

// ===== rtl/lkvc_pkg.sv =====
package lkvc_pkg;

  localparam int DATA_W  = 32;
  localparam int CAP_W   = 5;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
  localparam logic [DATA_W-1:0] NEG_ONE   = 32'hFFFF_FFFF;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Register index, taken from paddr above the byte offset.
  localparam logic REG_CAPACITY = 1'b0;

  // Flags that travel down the cell row with a lookup.
  typedef struct packed {
    logic active;
    logic hit;
    logic free_seen;
    logic lru_seen;
  } scan_t;

  // Update broadcast from the controller to every cell.
  typedef struct packed {
    logic clear;
    logic update;
    logic promote_all;
    logic write_entry;
    logic write_value;
  } commit_t;

endpackage

// ===== rtl/lru_key_value_cache.sv =====
// Channel   | Handshake                         | Payload
// ----------+-----------------------------------+-----------------------------------
// input     | start, busy (beat: start & !busy) | in_opcode, in_key, in_value
// result    | out_valid (one-cycle strobe)      | out_hit, out_read_value
// config    | psel, penable, pwrite, pready     | paddr, pwdata, prdata (capacity)
//
// A lookup walks the row of cells one cell per clock: the beat is registered,
// passes the scan register of each cell in turn, and strobes out of the result
// register. Busy is high until the cycle of the strobe, and the next beat can
// be taken in that cycle, so one lookup is in the row at a time. Synchronous
// reset clears all valid bits and the occupancy and sets capacity to 16; there
// is no clearing pass. The receiver cannot stall; a capacity write empties the store.
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_opcode,
  input  logic signed [lkvc_pkg::DATA_W-1:0] in_key,
  input  logic signed [lkvc_pkg::DATA_W-1:0] in_value,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic signed [lkvc_pkg::DATA_W-1:0] out_read_value,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lkvc_pkg::PADDR_W-1:0]  paddr,
  input  logic [lkvc_pkg::PDATA_W-1:0]  pwdata,
  output logic [lkvc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CW    = (OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W;

  logic [lkvc_pkg::CAP_W-1:0]  cap_r;
  logic                        busy_r, busy_nxt;
  logic                        go_r;
  logic                        op_r;
  logic [lkvc_pkg::DATA_W-1:0] key_r;
  logic [lkvc_pkg::DATA_W-1:0] value_r;
  logic [OCC_W-1:0]            occ_r, occ_nxt;
  logic                        out_valid_r;
  logic                        out_hit_r;
  logic [lkvc_pkg::DATA_W-1:0] out_read_value_r;

  logic accept;
  logic cap_wr;
  logic cap_sel;
  logic done;
  logic room;
  logic [CW-1:0] cap_ext, cap_eff;

  lkvc_pkg::commit_t commit;
  logic [IDX_W-1:0]  commit_slot;
  logic [IDX_W-1:0]  commit_limit;

  lkvc_pkg::scan_t             scan_c        [ENTRIES+1];
  logic [IDX_W-1:0]            found_idx_c   [ENTRIES+1];
  logic [IDX_W-1:0]            found_rank_c  [ENTRIES+1];
  logic [lkvc_pkg::DATA_W-1:0] found_value_c [ENTRIES+1];
  logic [IDX_W-1:0]            free_idx_c    [ENTRIES+1];
  logic [IDX_W-1:0]            lru_idx_c     [ENTRIES+1];

  assign accept  = start && !busy_r;
  assign cap_sel = (paddr[lkvc_pkg::PADDR_W-1:2] == lkvc_pkg::REG_CAPACITY);
  assign cap_wr  = psel && penable && pwrite && cap_sel;
  assign pready  = 1'b1;
  assign prdata  = cap_sel ? lkvc_pkg::PDATA_W'(cap_r) : '0;

  // Head of the row: a fresh record enters for one cycle after each beat.
  assign scan_c[0]        = '{active: go_r, hit: 1'b0, free_seen: 1'b0, lru_seen: 1'b0};
  assign found_idx_c[0]   = '0;
  assign found_rank_c[0]  = '0;
  assign found_value_c[0] = '0;
  assign free_idx_c[0]    = '0;
  assign lru_idx_c[0]     = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkvc_cell #(
      .ENTRIES  (ENTRIES),
      .CELL_IDX (i)
    ) u_cell (
      .clk             (clk),
      .rst_n           (rst_n),
      .commit          (commit),
      .commit_slot     (commit_slot),
      .commit_limit    (commit_limit),
      .item_key        (key_r),
      .item_value      (value_r),
      .occupancy       (occ_r),
      .scan_in         (scan_c[i]),
      .found_idx_in    (found_idx_c[i]),
      .found_rank_in   (found_rank_c[i]),
      .found_value_in  (found_value_c[i]),
      .free_idx_in     (free_idx_c[i]),
      .lru_idx_in      (lru_idx_c[i]),
      .scan_out        (scan_c[i+1]),
      .found_idx_out   (found_idx_c[i+1]),
      .found_rank_out  (found_rank_c[i+1]),
      .found_value_out (found_value_c[i+1]),
      .free_idx_out    (free_idx_c[i+1]),
      .lru_idx_out     (lru_idx_c[i+1])
    );
  end

  assign done = scan_c[ENTRIES].active;

  // Capacity zero acts as one, and anything above the row length as the row length.
  always_comb begin
    cap_ext = CW'(cap_r);
    cap_eff = cap_ext;
    if (cap_ext == '0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      cap_eff = CW'(ENTRIES);
    end
  end

  assign room = CW'(occ_r) < cap_eff;

  always_comb begin
    commit       = '0;
    commit_slot  = '0;
    commit_limit = '0;
    occ_nxt      = occ_r;
    if (cap_wr) begin
      commit.clear = 1'b1;
      occ_nxt      = '0;
    end else if (done) begin
      if (scan_c[ENTRIES].hit) begin
        commit.update      = 1'b1;
        commit.write_value = (op_r == lkvc_pkg::OP_PUT);
        commit_slot        = found_idx_c[ENTRIES];
        commit_limit       = found_rank_c[ENTRIES];
      end else if (op_r == lkvc_pkg::OP_PUT) begin
        if (room) begin
          if (scan_c[ENTRIES].free_seen) begin
            commit.update      = 1'b1;
            commit.promote_all = 1'b1;
            commit.write_entry = 1'b1;
            commit.write_value = 1'b1;
            commit_slot        = free_idx_c[ENTRIES];
            occ_nxt            = occ_r + OCC_W'(1);
          end
        end else if (scan_c[ENTRIES].lru_seen) begin
          // Full store: the least recent slot takes the new key.
          commit.update      = 1'b1;
          commit.promote_all = 1'b1;
          commit.write_entry = 1'b1;
          commit.write_value = 1'b1;
          commit_slot        = lru_idx_c[ENTRIES];
        end
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= lkvc_pkg::CAP_RESET;
      busy_r      <= 1'b0;
      go_r        <= 1'b0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cap_wr) begin
        cap_r <= pwdata[lkvc_pkg::CAP_W-1:0];
      end
      busy_r      <= busy_nxt;
      go_r        <= accept;
      occ_r       <= occ_nxt;
      out_valid_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_opcode;
      key_r   <= in_key;
      value_r <= in_value;
    end
    if (done) begin
      out_hit_r        <= scan_c[ENTRIES].hit;
      out_read_value_r <= (scan_c[ENTRIES].hit && (op_r == lkvc_pkg::OP_GET)) ?
                          found_value_c[ENTRIES] : lkvc_pkg::NEG_ONE;
    end
  end

  assign busy           = busy_r;
  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_read_value_r;

endmodule

// ===== rtl/lkvc_cell.sv =====
module lkvc_cell #(
  parameter int ENTRIES  = 16,
  parameter int CELL_IDX = 0,
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int OCC_W   = $clog2(ENTRIES + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lkvc_pkg::commit_t          commit,
  input  logic [IDX_W-1:0]           commit_slot,
  input  logic [IDX_W-1:0]           commit_limit,
  input  logic [lkvc_pkg::DATA_W-1:0] item_key,
  input  logic [lkvc_pkg::DATA_W-1:0] item_value,
  input  logic [OCC_W-1:0]           occupancy,
  input  lkvc_pkg::scan_t            scan_in,
  input  logic [IDX_W-1:0]           found_idx_in,
  input  logic [IDX_W-1:0]           found_rank_in,
  input  logic [lkvc_pkg::DATA_W-1:0] found_value_in,
  input  logic [IDX_W-1:0]           free_idx_in,
  input  logic [IDX_W-1:0]           lru_idx_in,
  output lkvc_pkg::scan_t            scan_out,
  output logic [IDX_W-1:0]           found_idx_out,
  output logic [IDX_W-1:0]           found_rank_out,
  output logic [lkvc_pkg::DATA_W-1:0] found_value_out,
  output logic [IDX_W-1:0]           free_idx_out,
  output logic [IDX_W-1:0]           lru_idx_out
);

  localparam int CMP_W = OCC_W + 1;
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                        valid_r, valid_nxt;
  logic [lkvc_pkg::DATA_W-1:0] key_r, key_nxt;
  logic [lkvc_pkg::DATA_W-1:0] value_r, value_nxt;
  logic [IDX_W-1:0]            rank_r, rank_nxt;

  lkvc_pkg::scan_t             scan_r, scan_nxt;
  logic [IDX_W-1:0]            found_idx_r, found_idx_nxt;
  logic [IDX_W-1:0]            found_rank_r, found_rank_nxt;
  logic [lkvc_pkg::DATA_W-1:0] found_value_r, found_value_nxt;
  logic [IDX_W-1:0]            free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]            lru_idx_r, lru_idx_nxt;

  logic is_lru;

  // The least recent entry is the one whose rank is occupancy minus one.
  assign is_lru = valid_r &&
                  ((CMP_W'(rank_r) + CMP_W'(1)) == CMP_W'(occupancy));

  // Scan stage: fold this cell's entry into the record and pass it on.
  always_comb begin
    scan_nxt        = scan_in;
    found_idx_nxt   = found_idx_in;
    found_rank_nxt  = found_rank_in;
    found_value_nxt = found_value_in;
    free_idx_nxt    = free_idx_in;
    lru_idx_nxt     = lru_idx_in;
    if (scan_in.active) begin
      if (!scan_in.hit && valid_r && (key_r == item_key)) begin
        scan_nxt.hit    = 1'b1;
        found_idx_nxt   = MY_IDX;
        found_rank_nxt  = rank_r;
        found_value_nxt = value_r;
      end
      if (!scan_in.free_seen && !valid_r) begin
        scan_nxt.free_seen = 1'b1;
        free_idx_nxt       = MY_IDX;
      end
      if (!scan_in.lru_seen && is_lru) begin
        scan_nxt.lru_seen = 1'b1;
        lru_idx_nxt       = MY_IDX;
      end
    end
  end

  // Entry update from the broadcast commit.
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    rank_nxt  = rank_r;
    if (commit.clear) begin
      valid_nxt = 1'b0;
    end else if (commit.update) begin
      if (commit_slot == MY_IDX) begin
        rank_nxt = '0;
        if (commit.write_entry) begin
          valid_nxt = 1'b1;
          key_nxt   = item_key;
        end
        if (commit.write_value) begin
          value_nxt = item_value;
        end
      end else if (valid_r && (commit.promote_all || (rank_r < commit_limit))) begin
        rank_nxt = rank_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      scan_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      scan_r  <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r         <= key_nxt;
    value_r       <= value_nxt;
    rank_r        <= rank_nxt;
    found_idx_r   <= found_idx_nxt;
    found_rank_r  <= found_rank_nxt;
    found_value_r <= found_value_nxt;
    free_idx_r    <= free_idx_nxt;
    lru_idx_r     <= lru_idx_nxt;
  end

  assign scan_out        = scan_r;
  assign found_idx_out   = found_idx_r;
  assign found_rank_out  = found_rank_r;
  assign found_value_out = found_value_r;
  assign free_idx_out    = free_idx_r;
  assign lru_idx_out     = lru_idx_r;

endmodule

// ===== rtl/lru_key_value_cache_checker.sv =====
`include "lru_key_value_cache_macros.svh"

module lru_key_value_cache_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_hit,
  input logic [31:0] out_read_value
);

  // An accepted beat holds the block busy until its result is out.
  `LKVC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

  // The result strobe comes with busy dropping, and never twice in a row.
  `LKVC_ASSERT_NOW(a_fall_strobe, $fell(busy), out_valid)
  `LKVC_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)

  // A miss always reports minus one.
  `LKVC_ASSERT_NOW(a_miss_value, out_valid && !out_hit, out_read_value == 32'hFFFF_FFFF)

endmodule

bind lru_key_value_cache lru_key_value_cache_checker u_lru_key_value_cache_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
module testbench;

  localparam int ENTRIES = 16;
  localparam int LATENCY = ENTRIES + 2;
  localparam int POOL_SIZE = 24;
  localparam int RANDOM_ITEMS = 185;
  localparam int NUM_PHASES = 9;
  localparam int NUM_ROWS = 25;
  localparam logic [lkvc_pkg::DATA_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [lkvc_pkg::DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [lkvc_pkg::PADDR_W-1:0] CAPACITY_ADDR = {lkvc_pkg::REG_CAPACITY, 2'b00};

  typedef struct packed {
    logic                        hit;
    logic [lkvc_pkg::DATA_W-1:0] read_value;
  } reply_t;

  typedef struct packed {
    logic                        opcode;
    logic [lkvc_pkg::DATA_W-1:0] key;
    logic [lkvc_pkg::DATA_W-1:0] value;
    logic                        typed;
    reply_t                      reply;
  } stim_row_t;

  localparam reply_t MISS = '{hit: 1'b0, read_value: lkvc_pkg::NEG_ONE};
  localparam reply_t PUT_HIT = '{hit: 1'b1, read_value: lkvc_pkg::NEG_ONE};

  // Directed rows. Keys 1 to 12 fill the store to its reset capacity, then one
  // more insert evicts the least recent key, which the final lookup then misses.
  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    '{lkvc_pkg::OP_GET, 32'd0,    32'd0,         1'b1, MISS},
    '{lkvc_pkg::OP_GET, WORD_MAX, lkvc_pkg::NEG_ONE, 1'b1, MISS},
    '{lkvc_pkg::OP_PUT, WORD_MIN, WORD_MAX,      1'b1, MISS},
    '{lkvc_pkg::OP_GET, WORD_MIN, 32'd0,         1'b1, '{1'b1, WORD_MAX}},
    '{lkvc_pkg::OP_PUT, WORD_MAX, WORD_MIN,      1'b1, MISS},
    '{lkvc_pkg::OP_GET, WORD_MAX, 32'h1234_5678, 1'b1, '{1'b1, WORD_MIN}},
    '{lkvc_pkg::OP_PUT, WORD_MIN, 32'd0,         1'b1, PUT_HIT},
    '{lkvc_pkg::OP_GET, WORD_MIN, lkvc_pkg::NEG_ONE, 1'b1, '{1'b1, 32'd0}},
    '{lkvc_pkg::OP_PUT, lkvc_pkg::NEG_ONE, lkvc_pkg::NEG_ONE, 1'b1, MISS},
    '{lkvc_pkg::OP_GET, lkvc_pkg::NEG_ONE, 32'd0, 1'b1, '{1'b1, lkvc_pkg::NEG_ONE}},
    '{lkvc_pkg::OP_PUT, 32'd0,    32'd1,         1'b1, MISS},
    '{lkvc_pkg::OP_PUT, 32'd1,    32'hA000_0001, 1'b0, MISS},
    '{lkvc_pkg::OP_PUT, 32'd2,    32'hA000_0002, 1'b0, MISS},
    '{lkvc_pkg::OP_PUT, 32'd3,    32'hA000_0003, 1'b0, MISS},
    '{lkvc_pkg::OP_PUT, 32'd4,    32'hA000_0004, 1'b0, MISS},
    '{lkvc_pkg::OP_PUT, 32'd5,    32'hA000_0005, 1'b0, MISS},
    '{lkvc_pkg::OP_PUT, 32'd6,    32'hA000_0006, 1'b0, MISS},
    '{lkvc_pkg::OP_PUT, 32'd7,    32'hA000_0007, 1'b0, MISS},
    '{lkvc_pkg::OP_PUT, 32'd8,    32'hA000_0008, 1'b0, MISS},
    '{lkvc_pkg::OP_PUT, 32'd9,    32'hA000_0009, 1'b0, MISS},
    '{lkvc_pkg::OP_PUT, 32'd10,   32'hA000_000A, 1'b0, MISS},
    '{lkvc_pkg::OP_PUT, 32'd11,   32'hA000_000B, 1'b0, MISS},
    '{lkvc_pkg::OP_PUT, 32'd12,   32'hA000_000C, 1'b0, MISS},
    '{lkvc_pkg::OP_PUT, 32'd100,  32'h5555_AAAA, 1'b0, MISS},
    '{lkvc_pkg::OP_GET, WORD_MAX, 32'd0,         1'b0, MISS}
  };

  // Capacity written before each phase (the first keeps the reset value).
  localparam logic [lkvc_pkg::CAP_W-1:0] PHASE_CAPACITY [NUM_PHASES] =
    '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd17, 5'd9, 5'd16, 5'd2};
  localparam int PHASE_IDLE_PCT [NUM_PHASES] = '{0, 51, 14, 0, 51, 14, 51, 0, 14};
  localparam logic [lkvc_pkg::DATA_W-1:0] EXTREMES [4] =
    '{32'd0, WORD_MIN, WORD_MAX, lkvc_pkg::NEG_ONE};

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic                         in_opcode;
  logic [lkvc_pkg::DATA_W-1:0]  in_key;
  logic [lkvc_pkg::DATA_W-1:0]  in_value;
  logic                         out_valid;
  logic                         out_hit;
  logic [lkvc_pkg::DATA_W-1:0]  out_read_value;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [lkvc_pkg::PADDR_W-1:0] paddr;
  logic [lkvc_pkg::PDATA_W-1:0] pwdata;
  logic [lkvc_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  // Shadow copy of the cache contents and recency order.
  logic                        shadow_valid [ENTRIES];
  logic [lkvc_pkg::DATA_W-1:0] shadow_key [ENTRIES];
  logic [lkvc_pkg::DATA_W-1:0] shadow_value [ENTRIES];
  int unsigned                 shadow_rank [ENTRIES];
  int unsigned                 shadow_occupancy;
  logic [lkvc_pkg::CAP_W-1:0]  shadow_capacity;

  reply_t                      pending_replies [$];
  logic [lkvc_pkg::DATA_W-1:0] key_pool [POOL_SIZE];
  int                          mismatch_count;

  lru_key_value_cache #(
    .ENTRIES(ENTRIES)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_key        (in_key),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_hit       (out_hit),
    .out_read_value(out_read_value),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic void empty_shadow();
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
    end
    shadow_occupancy = 0;
  endfunction

  function automatic int unsigned usable_entries();
    int unsigned cap;
    cap = 32'(shadow_capacity);
    if (cap < 1) cap = 1;
    if (cap > ENTRIES) cap = ENTRIES;
    return cap;
  endfunction

  // Slot becomes most recent; valid entries more recent than limit age by one.
  function automatic void make_most_recent(int slot, int unsigned limit);
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_valid[i] && i != slot && shadow_rank[i] < limit) begin
        shadow_rank[i] = shadow_rank[i] + 1;
      end
    end
    shadow_rank[slot] = 0;
  endfunction

  function automatic reply_t cache_lookup(logic opcode, logic [lkvc_pkg::DATA_W-1:0] key,
                                          logic [lkvc_pkg::DATA_W-1:0] value);
    int     found = -1;
    int     slot = -1;
    reply_t r;
    for (int i = 0; i < ENTRIES; i++) begin
      if (found < 0 && shadow_valid[i] && shadow_key[i] == key) found = i;
    end
    r.hit = (found >= 0);
    r.read_value = lkvc_pkg::NEG_ONE;
    if (found >= 0) begin
      if (opcode == lkvc_pkg::OP_GET) r.read_value = shadow_value[found];
      else shadow_value[found] = value;
      make_most_recent(found, shadow_rank[found]);
      return r;
    end
    if (opcode == lkvc_pkg::OP_GET) return r;
    if (shadow_occupancy < usable_entries()) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot < 0 && !shadow_valid[i]) slot = i;
      end
      if (slot >= 0) shadow_occupancy = shadow_occupancy + 1;
    end else begin
      // Full: the least recent entry gives up its slot.
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot < 0 && shadow_valid[i] && shadow_rank[i] + 1 == shadow_occupancy) slot = i;
      end
    end
    if (slot >= 0) begin
      shadow_valid[slot] = 1'b1;
      shadow_key[slot] = key;
      shadow_value[slot] = value;
      make_most_recent(slot, 32'hFFFF_FFFF);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [lkvc_pkg::DATA_W-1:0] got,
                                 logic [lkvc_pkg::DATA_W-1:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : result_check
    reply_t want;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected result, read_value", out_read_value, lkvc_pkg::NEG_ONE);
      end else begin
        want = pending_replies.pop_front();
        if (out_hit !== want.hit)
          report_mismatch("hit", lkvc_pkg::DATA_W'(out_hit), lkvc_pkg::DATA_W'(want.hit));
        if (out_read_value !== want.read_value)
          report_mismatch("read_value", out_read_value, want.read_value);
      end
    end
  end

  // Holds start high until the beat is taken. Start is left high so that a
  // following item keeps it up without a drop in between.
  task automatic send_item(logic opcode, logic [lkvc_pkg::DATA_W-1:0] key,
                           logic [lkvc_pkg::DATA_W-1:0] value,
                           logic typed, reply_t typed_reply);
    reply_t predicted;
    start <= 1'b1;
    in_opcode <= opcode;
    in_key <= key;
    in_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = cache_lookup(opcode, key, value);
    pending_replies.push_back(typed ? typed_reply : predicted);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_replies.size() > 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [lkvc_pkg::PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAPACITY_ADDR;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    shadow_capacity = data[lkvc_pkg::CAP_W-1:0];
    empty_shadow();
  endtask

  task automatic cfg_read_check();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= CAPACITY_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[lkvc_pkg::CAP_W-1:0] !== shadow_capacity)
      report_mismatch("capacity readback", prdata, lkvc_pkg::DATA_W'(shadow_capacity));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic int pick_gap(int idle_pct);
    int gap = 0;
    while ($urandom_range(0, 99) < idle_pct && gap < 40) gap++;
    return gap;
  endfunction

  task automatic run_random(int idle_pct);
    int                          span;
    logic                        opcode;
    logic [lkvc_pkg::DATA_W-1:0] key;
    logic [lkvc_pkg::DATA_W-1:0] value;
    // Keys mostly come from a pool a little larger than the capacity, so that
    // hits, updates and evictions all happen often.
    span = usable_entries() + 4;
    repeat (RANDOM_ITEMS) begin
      opcode = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) key = $urandom;
      else key = key_pool[$urandom_range(0, span - 1)];
      if ($urandom_range(0, 15) == 0) value = EXTREMES[$urandom_range(0, 3)];
      else value = $urandom;
      send_item(opcode, key, value, 1'b0, MISS);
      if ($urandom_range(0, 63) == 0) wait_drained();
      else idle_cycles(pick_gap(idle_pct));
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_opcode <= lkvc_pkg::OP_GET;
    in_key <= '0;
    in_value <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    mismatch_count = 0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = (i < 4) ? EXTREMES[i] : $urandom;
    end
    shadow_capacity = lkvc_pkg::CAP_RESET;
    empty_shadow();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    cfg_read_check();
    for (int r = 0; r < NUM_ROWS; r++) begin
      send_item(DIRECTED[r].opcode, DIRECTED[r].key, DIRECTED[r].value,
                DIRECTED[r].typed, DIRECTED[r].reply);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        // The store must be quiet before the capacity changes.
        wait_drained();
        cfg_write({27'($urandom), PHASE_CAPACITY[p]});
        cfg_read_check();
      end
      run_random(PHASE_IDLE_PCT[p]);
    end

    wait_drained();
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
